FILE: hw/rtl/prnfa_pkg.sv
package prnfa_pkg;

  localparam int DEF_MAX_STATES  = 128;
  localparam int DEF_STACK_DEPTH = 16;
  localparam int CMD_QUEUE_DEPTH = 4;

  localparam logic [7:0] TOK_CONCAT = 8'd46;
  localparam logic [7:0] TOK_ALT    = 8'd43;
  localparam logic [7:0] TOK_STAR   = 8'd42;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNDERFLOW = 3'd1;
  localparam logic [2:0] ST_OVERFLOW  = 3'd2;
  localparam logic [2:0] ST_EXHAUSTED = 3'd3;
  localparam logic [2:0] ST_EXTRA     = 3'd4;

  localparam logic REC_TRANS = 1'b0;
  localparam logic REC_DONE  = 1'b1;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_LIT  = 3'd1,
    OP_CAT  = 3'd2,
    OP_ALT  = 3'd3,
    OP_STAR = 3'd4
  } op_t;

  localparam int OP_W = 3;

  typedef struct packed {
    logic       rec_kind;
    logic [6:0] from_state;
    logic       slot;
    logic [7:0] symbol;
    logic       is_epsilon;
    logic [6:0] to_state;
    logic [6:0] start_state;
    logic [6:0] accept_state;
    logic [2:0] status;
    logic       run_end;
  } rec_t;

  function automatic int cmd_width(input int id_w);
    return 7 * id_w + OP_W + 1 + 8 + 3;
  endfunction

endpackage

FILE: hw/rtl/prnfa_front.sv
module prnfa_front #(
  parameter int MAX_STATES  = prnfa_pkg::DEF_MAX_STATES,
  parameter int STACK_DEPTH = prnfa_pkg::DEF_STACK_DEPTH,
  localparam int CMD_W = prnfa_pkg::cmd_width($clog2(MAX_STATES))
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [7:0]       in_token,
  input  logic             in_last,
  input  logic             q_full,
  output logic             q_push,
  output logic [CMD_W-1:0] q_data
);
  import prnfa_pkg::*;

  localparam int ID_W  = $clog2(MAX_STATES);
  localparam int NID_W = $clog2(MAX_STATES + 1);
  localparam int DEP_W = $clog2(STACK_DEPTH + 1);
  localparam int AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  typedef struct packed {
    logic [ID_W-1:0] st;
    logic [ID_W-1:0] fin;
  } frag_t;

  typedef struct packed {
    op_t             op;
    logic            last;
    logic [7:0]      sym;
    logic [ID_W-1:0] s;
    logic [ID_W-1:0] a_s;
    logic [ID_W-1:0] a_f;
    logic [ID_W-1:0] b_s;
    logic [ID_W-1:0] b_f;
    logic [ID_W-1:0] d_start;
    logic [ID_W-1:0] d_acc;
    logic [2:0]      status;
  } cmd_t;

  frag_t            stack_mem [STACK_DEPTH];
  frag_t            top_r, top_nxt;
  frag_t            sec_r, sec_nxt;
  frag_t            third_r;
  logic [DEP_W-1:0] depth_r, depth_nxt, depth_aft;
  logic [NID_W-1:0] nid_r, nid_nxt;
  logic [2:0]       err_r, err_nxt, err_aft;

  logic             accept;
  logic             is_cat, is_alt, is_star, is_op;
  logic             underflow, overflow, exhaust, ok;
  logic [NID_W:0]   nid_plus2;
  logic [ID_W-1:0]  s_id, f_id;
  logic [DEP_W-1:0] dm2, dm4;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic             mem_we, mem_re;
  op_t              op;
  cmd_t             cmd;

  assign accept = push && !q_full;

  always_comb begin
    is_cat    = (in_token == TOK_CONCAT);
    is_alt    = (in_token == TOK_ALT);
    is_star   = (in_token == TOK_STAR);
    is_op     = is_cat || is_alt || is_star;
    underflow = is_op && (is_star ? (depth_r == '0) : (depth_r < DEP_W'(2)));
    overflow  = !is_op && (depth_r == DEP_W'(STACK_DEPTH));
    nid_plus2 = {1'b0, nid_r} + (NID_W + 1)'(2);
    exhaust   = nid_plus2 > (NID_W + 1)'(MAX_STATES);
    ok        = (err_r == ST_OK) && !underflow && !overflow && !exhaust;

    err_aft = err_r;
    if (err_r == ST_OK) begin
      if (underflow) begin
        err_aft = ST_UNDERFLOW;
      end else if (overflow) begin
        err_aft = ST_OVERFLOW;
      end else if (exhaust) begin
        err_aft = ST_EXHAUSTED;
      end
    end

    s_id = nid_r[ID_W-1:0];
    f_id = s_id + ID_W'(1);
    dm2  = depth_r - DEP_W'(2);
    dm4  = depth_r - DEP_W'(4);
    wr_addr = dm2[AW-1:0];
    rd_addr = dm4[AW-1:0];

    op        = OP_NONE;
    top_nxt   = top_r;
    sec_nxt   = sec_r;
    depth_aft = depth_r;
    nid_nxt   = nid_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    if (ok) begin
      top_nxt = '{st: s_id, fin: f_id};
      nid_nxt = nid_plus2[NID_W-1:0];
      if (!is_op) begin
        op        = OP_LIT;
        sec_nxt   = top_r;
        depth_aft = depth_r + DEP_W'(1);
        mem_we    = (depth_r >= DEP_W'(2));
      end else if (is_star) begin
        op = OP_STAR;
      end else begin
        op        = is_cat ? OP_CAT : OP_ALT;
        sec_nxt   = third_r;
        depth_aft = depth_r - DEP_W'(1);
        mem_re    = 1'b1;
      end
    end

    cmd.op      = op;
    cmd.last    = in_last;
    cmd.sym     = in_token;
    cmd.s       = s_id;
    cmd.a_s     = is_star ? top_r.st : sec_r.st;
    cmd.a_f     = is_star ? top_r.fin : sec_r.fin;
    cmd.b_s     = top_r.st;
    cmd.b_f     = top_r.fin;
    cmd.d_start = '0;
    cmd.d_acc   = '0;
    cmd.status  = err_aft;
    if (err_aft == ST_OK) begin
      if (depth_aft == '0) begin
        cmd.status = ST_UNDERFLOW;
      end else begin
        cmd.d_start = top_nxt.st;
        cmd.d_acc   = top_nxt.fin;
        if (depth_aft > DEP_W'(1)) begin
          cmd.status = ST_EXTRA;
        end
      end
    end

    if (in_last) begin
      depth_nxt = '0;
      nid_nxt   = '0;
      err_nxt   = ST_OK;
    end else begin
      depth_nxt = depth_aft;
      err_nxt   = err_aft;
    end
  end

  assign q_push = accept && ((op != OP_NONE) || in_last);
  assign q_data = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      nid_r   <= '0;
      err_r   <= ST_OK;
    end else if (accept) begin
      depth_r <= depth_nxt;
      nid_r   <= nid_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      top_r <= top_nxt;
      sec_r <= sec_nxt;
      if (mem_we) begin
        stack_mem[wr_addr] <= sec_r;
      end
      if (ok && !is_op) begin
        third_r <= sec_r;
      end else if (mem_re) begin
        third_r <= stack_mem[rd_addr];
      end
    end
  end

endmodule

FILE: hw/rtl/prnfa_fifo.sv
module prnfa_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = prnfa_pkg::CMD_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rd_data
);
  import prnfa_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_wr, do_rd;

  assign full     = (count_r == CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = slots[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_rd) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + CW'(1);
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr_r] <= wr_data;
    end
  end

endmodule

FILE: hw/rtl/prnfa_back.sv
module prnfa_back #(
  parameter int MAX_STATES = prnfa_pkg::DEF_MAX_STATES,
  localparam int CMD_W = prnfa_pkg::cmd_width($clog2(MAX_STATES))
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  logic [CMD_W-1:0] q_data,
  output logic             q_pop,
  input  logic             pop,
  output logic             empty,
  output prnfa_pkg::rec_t  out_rec
);
  import prnfa_pkg::*;

  localparam int ID_W = $clog2(MAX_STATES);

  typedef struct packed {
    op_t             op;
    logic            last;
    logic [7:0]      sym;
    logic [ID_W-1:0] s;
    logic [ID_W-1:0] a_s;
    logic [ID_W-1:0] a_f;
    logic [ID_W-1:0] b_s;
    logic [ID_W-1:0] b_f;
    logic [ID_W-1:0] d_start;
    logic [ID_W-1:0] d_acc;
    logic [2:0]      status;
  } cmd_t;

  cmd_t            cmd;
  rec_t            rec, out_r;
  logic            out_vld_r;
  logic [2:0]      k_r;
  logic [2:0]      n_trans, n_recs;
  logic [ID_W-1:0] f_id;
  logic            load;

  function automatic logic [6:0] to7(input logic [ID_W-1:0] v);
    logic [ID_W+6:0] w;
    w = {7'b0, v};
    return w[6:0];
  endfunction

  function automatic rec_t eps_rec(input logic [ID_W-1:0] from, input logic sl,
                                   input logic [ID_W-1:0] to);
    rec_t r;
    r            = '0;
    r.rec_kind   = REC_TRANS;
    r.from_state = to7(from);
    r.slot       = sl;
    r.is_epsilon = 1'b1;
    r.to_state   = to7(to);
    return r;
  endfunction

  always_comb begin
    cmd  = q_data;
    f_id = cmd.s + ID_W'(1);
    case (cmd.op)
      OP_LIT:  n_trans = 3'd1;
      OP_CAT:  n_trans = 3'd3;
      OP_ALT:  n_trans = 3'd4;
      OP_STAR: n_trans = 3'd4;
      default: n_trans = 3'd0;
    endcase
    n_recs = n_trans + {2'b0, cmd.last};

    rec = '0;
    if (k_r < n_trans) begin
      case (cmd.op)
        OP_LIT: begin
          rec.rec_kind   = REC_TRANS;
          rec.from_state = to7(cmd.s);
          rec.symbol     = cmd.sym;
          rec.to_state   = to7(f_id);
        end
        OP_CAT: begin
          case (k_r)
            3'd0:    rec = eps_rec(cmd.s, 1'b0, cmd.a_s);
            3'd1:    rec = eps_rec(cmd.a_f, 1'b0, cmd.b_s);
            default: rec = eps_rec(cmd.b_f, 1'b0, f_id);
          endcase
        end
        OP_ALT: begin
          case (k_r)
            3'd0:    rec = eps_rec(cmd.s, 1'b0, cmd.a_s);
            3'd1:    rec = eps_rec(cmd.s, 1'b1, cmd.b_s);
            3'd2:    rec = eps_rec(cmd.a_f, 1'b0, f_id);
            default: rec = eps_rec(cmd.b_f, 1'b0, f_id);
          endcase
        end
        OP_STAR: begin
          case (k_r)
            3'd0:    rec = eps_rec(cmd.s, 1'b0, cmd.a_s);
            3'd1:    rec = eps_rec(cmd.s, 1'b1, f_id);
            3'd2:    rec = eps_rec(cmd.a_f, 1'b0, f_id);
            default: rec = eps_rec(cmd.a_f, 1'b1, cmd.a_s);
          endcase
        end
        default: rec = '0;
      endcase
    end else begin
      rec.rec_kind     = REC_DONE;
      rec.start_state  = to7(cmd.d_start);
      rec.accept_state = to7(cmd.d_acc);
      rec.status       = cmd.status;
    end
    rec.run_end = (k_r == n_recs - 3'd1);

    load  = q_valid && (n_recs != '0) && (!out_vld_r || pop);
    q_pop = q_valid && ((n_recs == '0) || (load && rec.run_end));
  end

  assign empty   = !out_vld_r;
  assign out_rec = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      k_r       <= '0;
    end else begin
      if (load) begin
        out_vld_r <= 1'b1;
      end else if (pop) begin
        out_vld_r <= 1'b0;
      end
      if (q_pop) begin
        k_r <= '0;
      end else if (load) begin
        k_r <= k_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= rec;
    end
  end

endmodule

FILE: hw/rtl/postfix_regex_to_nfa_builder.sv
// Builds a Thompson NFA from a postfix regular expression, one token per transfer.
// The input side is a queue: a token transfers when push is high and full is low.
// The '.' byte concatenates, '+' alternates, '*' applies the star, and any other
// byte is a literal. The token marked by in_last closes the expression.
// Results leave through a queue: the oldest record sits on the out_ ports while
// empty is low and transfers when pop is high. Until an error, a literal yields
// one transition record, concatenation three, alternation and star four; the
// last token adds a done record with start state, accepting state and status.
// The first record of a token passes through the command queue and the output
// register before it appears. The output register sends one record per cycle
// while pop is high; the front end takes a token every cycle while its
// four-entry command queue has room. When pop stays low the output register
// holds, the command queue fills and full rises; nothing is dropped.
// Synchronous reset clears the fragment stack depth, the state counter, the
// error flag and both queues; after a done record the builder starts over at
// state zero without a reset.
module postfix_regex_to_nfa_builder #(
  parameter int MAX_STATES  = prnfa_pkg::DEF_MAX_STATES,
  parameter int STACK_DEPTH = prnfa_pkg::DEF_STACK_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_token,
  input  logic       in_last,
  input  logic       pop,
  output logic       empty,
  output logic       out_rec_kind,
  output logic [6:0] out_from_state,
  output logic       out_slot,
  output logic [7:0] out_symbol,
  output logic       out_is_epsilon,
  output logic [6:0] out_to_state,
  output logic [6:0] out_start_state,
  output logic [6:0] out_accept_state,
  output logic [2:0] out_status,
  output logic       out_run_end
);
  import prnfa_pkg::*;

  localparam int CMD_W = cmd_width($clog2(MAX_STATES));

  logic             f_push, q_full, q_valid, q_pop;
  logic [CMD_W-1:0] f_data, q_data;
  rec_t             rec;

  prnfa_front #(
    .MAX_STATES (MAX_STATES),
    .STACK_DEPTH(STACK_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_token(in_token),
    .in_last (in_last),
    .q_full  (q_full),
    .q_push  (f_push),
    .q_data  (f_data)
  );

  prnfa_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(CMD_QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (f_push),
    .wr_data (f_data),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_valid(q_valid),
    .rd_data (q_data)
  );

  prnfa_back #(
    .MAX_STATES(MAX_STATES)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_valid(q_valid),
    .q_data (q_data),
    .q_pop  (q_pop),
    .pop    (pop),
    .empty  (empty),
    .out_rec(rec)
  );

  assign full             = q_full;
  assign out_rec_kind     = rec.rec_kind;
  assign out_from_state   = rec.from_state;
  assign out_slot         = rec.slot;
  assign out_symbol       = rec.symbol;
  assign out_is_epsilon   = rec.is_epsilon;
  assign out_to_state     = rec.to_state;
  assign out_start_state  = rec.start_state;
  assign out_accept_state = rec.accept_state;
  assign out_status       = rec.status;
  assign out_run_end      = rec.run_end;

endmodule

FILE: test/postfix_regex_to_nfa_builder_tb.sv
module postfix_regex_to_nfa_builder_tb;
  import prnfa_pkg::*;

  localparam int STATE_MAX = DEF_MAX_STATES;
  localparam int STACK_MAX = DEF_STACK_DEPTH;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_QUIET = 10;

  typedef struct {
    logic [7:0] tok;
    logic       is_last;
    logic       hold;
    int         gap_max;
  } tok_item_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_token = 8'd0;
  logic       in_last = 1'b0;
  logic       pop = 1'b0;
  logic       empty;
  logic       out_rec_kind;
  logic [6:0] out_from_state;
  logic       out_slot;
  logic [7:0] out_symbol;
  logic       out_is_epsilon;
  logic [6:0] out_to_state;
  logic [6:0] out_start_state;
  logic [6:0] out_accept_state;
  logic [2:0] out_status;
  logic       out_run_end;

  tok_item_t   tokens_pending[$];
  rec_t        nfa_recs[$];
  int unsigned frag_start[STACK_MAX];
  int unsigned frag_final[STACK_MAX];
  int unsigned frag_count = 0;
  int unsigned id_next = 0;
  logic [2:0]  build_err = ST_OK;

  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  int   idle_cycles = 0;
  int   in_gap = 0;
  int   cur_gap_max = 0;
  int   out_gap = 0;
  int   out_count = 0;
  int   mismatches = 0;

  postfix_regex_to_nfa_builder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_token         (in_token),
    .in_last          (in_last),
    .pop              (pop),
    .empty            (empty),
    .out_rec_kind     (out_rec_kind),
    .out_from_state   (out_from_state),
    .out_slot         (out_slot),
    .out_symbol       (out_symbol),
    .out_is_epsilon   (out_is_epsilon),
    .out_to_state     (out_to_state),
    .out_start_state  (out_start_state),
    .out_accept_state (out_accept_state),
    .out_status       (out_status),
    .out_run_end      (out_run_end)
  );

  always #2 clk = ~clk;

  function automatic rec_t trans_rec(int unsigned from, logic slot, logic [7:0] sym,
                                     logic eps, int unsigned to);
    rec_t r;
    r = '0;
    r.rec_kind   = REC_TRANS;
    r.from_state = 7'(from);
    r.slot       = slot;
    r.symbol     = sym;
    r.is_epsilon = eps;
    r.to_state   = 7'(to);
    return r;
  endfunction

  task automatic build_step(logic [7:0] tok, logic is_last);
    logic        is_op;
    int unsigned need;
    int unsigned s, f, a_s, a_f, b_s, b_f;
    int          n0;
    rec_t        done;
    logic [2:0]  st;
    n0 = nfa_recs.size();
    is_op = (tok == TOK_CONCAT) || (tok == TOK_ALT) || (tok == TOK_STAR);
    need = (tok == TOK_STAR) ? 1 : 2;
    if (build_err == ST_OK) begin
      if (is_op && frag_count < need) begin
        build_err = ST_UNDERFLOW;
      end else if (!is_op && frag_count >= STACK_MAX) begin
        build_err = ST_OVERFLOW;
      end else if (id_next + 2 > STATE_MAX) begin
        build_err = ST_EXHAUSTED;
      end else begin
        s = id_next;
        f = id_next + 1;
        id_next += 2;
        if (!is_op) begin
          nfa_recs.push_back(trans_rec(s, 1'b0, tok, 1'b0, f));
        end else if (tok == TOK_STAR) begin
          a_s = frag_start[frag_count-1];
          a_f = frag_final[frag_count-1];
          frag_count -= 1;
          nfa_recs.push_back(trans_rec(s, 1'b0, 8'd0, 1'b1, a_s));
          nfa_recs.push_back(trans_rec(s, 1'b1, 8'd0, 1'b1, f));
          nfa_recs.push_back(trans_rec(a_f, 1'b0, 8'd0, 1'b1, f));
          nfa_recs.push_back(trans_rec(a_f, 1'b1, 8'd0, 1'b1, a_s));
        end else begin
          b_s = frag_start[frag_count-1];
          b_f = frag_final[frag_count-1];
          a_s = frag_start[frag_count-2];
          a_f = frag_final[frag_count-2];
          frag_count -= 2;
          nfa_recs.push_back(trans_rec(s, 1'b0, 8'd0, 1'b1, a_s));
          if (tok == TOK_CONCAT) begin
            nfa_recs.push_back(trans_rec(a_f, 1'b0, 8'd0, 1'b1, b_s));
            nfa_recs.push_back(trans_rec(b_f, 1'b0, 8'd0, 1'b1, f));
          end else begin
            nfa_recs.push_back(trans_rec(s, 1'b1, 8'd0, 1'b1, b_s));
            nfa_recs.push_back(trans_rec(a_f, 1'b0, 8'd0, 1'b1, f));
            nfa_recs.push_back(trans_rec(b_f, 1'b0, 8'd0, 1'b1, f));
          end
        end
        frag_start[frag_count] = s;
        frag_final[frag_count] = f;
        frag_count += 1;
      end
    end
    if (is_last) begin
      done = '0;
      done.rec_kind = REC_DONE;
      st = build_err;
      if (st == ST_OK) begin
        if (frag_count == 0) begin
          st = ST_UNDERFLOW;
        end else begin
          done.start_state  = 7'(frag_start[frag_count-1]);
          done.accept_state = 7'(frag_final[frag_count-1]);
          if (frag_count > 1) st = ST_EXTRA;
        end
      end
      done.status = st;
      nfa_recs.push_back(done);
      frag_count = 0;
      id_next = 0;
      build_err = ST_OK;
    end
    if (nfa_recs.size() > n0) nfa_recs[nfa_recs.size()-1].run_end = 1'b1;
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    rec_t want;
    if (rst_n) begin
      in_taken <= push && !full;
      out_taken <= pop && !empty;
      if ((push && !full) || (pop && !empty && nfa_recs.size() > 0)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (pop && !empty) begin
        out_count++;
        if (nfa_recs.size() == 0) begin
          $error("unexpected record transfer: kind %0d", out_rec_kind);
          mismatches++;
        end else begin
          want = nfa_recs.pop_front();
          check_field("rec_kind", int'(want.rec_kind), int'(out_rec_kind));
          check_field("from_state", int'(want.from_state), int'(out_from_state));
          check_field("slot", int'(want.slot), int'(out_slot));
          check_field("symbol", int'(want.symbol), int'(out_symbol));
          check_field("is_epsilon", int'(want.is_epsilon), int'(out_is_epsilon));
          check_field("to_state", int'(want.to_state), int'(out_to_state));
          check_field("start_state", int'(want.start_state), int'(out_start_state));
          check_field("accept_state", int'(want.accept_state), int'(out_accept_state));
          check_field("status", int'(want.status), int'(out_status));
          check_field("run_end", int'(want.run_end), int'(out_run_end));
        end
      end
      if (push && !full) build_step(in_token, in_last);
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(negedge clk) begin
    logic      nxt_push;
    tok_item_t it;
    if (rst_n) begin
      nxt_push = push;
      if (push && in_taken) begin
        nxt_push = 1'b0;
        in_gap = (cur_gap_max == 0) ? 0 : $urandom_range(0, cur_gap_max);
      end else if (!push && in_gap > 0) begin
        in_gap--;
      end
      if (!nxt_push && in_gap == 0 && tokens_pending.size() > 0) begin
        if (!tokens_pending[0].hold || (nfa_recs.size() == 0 && idle_cycles >= DRAIN_QUIET)) begin
          it = tokens_pending.pop_front();
          in_token <= it.tok;
          in_last <= it.is_last;
          cur_gap_max = it.gap_max;
          nxt_push = 1'b1;
        end
      end
      push <= nxt_push;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) out_gap = ((out_count / 40) % 4 == 0) ? 0 : $urandom_range(0, 8);
      if (out_gap > 0) begin
        out_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic add_tok(logic [7:0] tok, logic is_last, logic hold, int gmax);
    tok_item_t it;
    it.tok = tok;
    it.is_last = is_last;
    it.hold = hold;
    it.gap_max = gmax;
    tokens_pending.push_back(it);
  endtask

  task automatic queue_expr(logic [7:0] seq[$], logic hold, int gmax);
    for (int i = 0; i < seq.size(); i++) begin
      add_tok(seq[i], i == seq.size() - 1, hold && i == 0, gmax);
    end
  endtask

  function automatic logic [7:0] rand_lit();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == TOK_CONCAT || b == TOK_ALT || b == TOK_STAR) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(0, 2))
      0: return TOK_CONCAT;
      1: return TOK_ALT;
      default: return TOK_STAR;
    endcase
  endfunction

  initial begin
    logic [7:0] seq[$];
    int  kind, n_lit, made, depth, stars, target, len, gmax;
    logic hold, did_exhaust;
    did_exhaust = 1'b0;

    seq = {8'd0};
    queue_expr(seq, 1'b0, 8);
    seq = {8'd101, 8'd255, TOK_ALT, TOK_STAR, 8'd128, TOK_CONCAT};
    queue_expr(seq, 1'b0, 0);
    seq = {TOK_CONCAT};
    queue_expr(seq, 1'b1, 8);
    seq = {TOK_STAR};
    queue_expr(seq, 1'b0, 8);
    seq = {8'd7, TOK_ALT};
    queue_expr(seq, 1'b0, 8);
    seq = {8'd1, 8'd2};
    queue_expr(seq, 1'b0, 0);
    seq = {TOK_ALT, 8'd3, 8'd4};
    queue_expr(seq, 1'b0, 8);
    seq = {8'd65, TOK_STAR, TOK_STAR};
    queue_expr(seq, 1'b0, 8);

    while (tokens_pending.size() < 350) begin
      kind = $urandom_range(0, 99);
      if (!did_exhaust && tokens_pending.size() >= 150) kind = 77;
      hold = ($urandom_range(0, 9) == 0);
      gmax = ($urandom_range(0, 4) == 0) ? 0 : 8;
      seq.delete();
      if (kind < 68) begin
        n_lit = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 16) : $urandom_range(1, 5);
        made = 0;
        depth = 0;
        stars = 0;
        while (made < n_lit || depth > 1) begin
          if (made < n_lit && depth < STACK_MAX && (depth < 2 || $urandom_range(0, 2) != 0)) begin
            seq.push_back(rand_lit());
            made++;
            depth++;
          end else if (depth >= 1 && stars < 8 && $urandom_range(0, 3) == 0) begin
            seq.push_back(TOK_STAR);
            stars++;
          end else if (depth >= 2) begin
            seq.push_back($urandom_range(0, 1) ? TOK_CONCAT : TOK_ALT);
            depth--;
          end
        end
        queue_expr(seq, hold, gmax);
      end else if (kind < 76) begin
        n_lit = STACK_MAX + 1 + $urandom_range(0, 2);
        for (int i = 0; i < n_lit; i++) seq.push_back(rand_lit());
        if ($urandom_range(0, 1)) seq.push_back(rand_op());
        queue_expr(seq, hold, gmax);
      end else if (kind < 80) begin
        did_exhaust = 1'b1;
        target = STATE_MAX / 2 + 1 + $urandom_range(0, 3);
        seq.push_back(rand_lit());
        while (seq.size() < target) begin
          if (target - seq.size() == 1 || $urandom_range(0, 2) == 0) begin
            seq.push_back(TOK_STAR);
          end else begin
            seq.push_back(rand_lit());
            seq.push_back($urandom_range(0, 1) ? TOK_CONCAT : TOK_ALT);
          end
        end
        queue_expr(seq, hold, gmax);
      end else begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          add_tok(($urandom_range(0, 2) == 0) ? rand_op() : 8'($urandom_range(0, 255)),
                  (i == len - 1) || ($urandom_range(0, 3) == 0), hold && i == 0, gmax);
        end
      end
    end

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    while (tokens_pending.size() > 0 || push || nfa_recs.size() > 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
